[rtl/core/bta_pkg.sv]
// ----------------------------------------------------------------------------
// bta_pkg
// Types, codes and helpers shared by the boundary-tag allocator modules.
// ----------------------------------------------------------------------------
package bta_pkg;

  localparam int unsigned HEAP_UNITS      = 1024;
  localparam int unsigned ALIGN_BYTES     = 8;
  localparam int unsigned MIN_BLOCK_BYTES = 32;
  localparam int unsigned TAG_BYTES       = 8;
  localparam int unsigned META_BYTES      = 8;

  localparam int unsigned UNIT_SHIFT = $clog2(ALIGN_BYTES);
  localparam int unsigned SLOT_W     = $clog2(HEAP_UNITS);
  localparam int unsigned TAG_W      = 12;
  localparam int unsigned FIELD_W    = 13;
  localparam int unsigned CFG_W      = 14;
  localparam int unsigned POS_W      = 13;
  localparam int unsigned END_W      = SLOT_W + 1;
  localparam int unsigned STEP_W     = SLOT_W + 1;
  localparam int unsigned OLD_W      = TAG_W - 1;

  localparam logic [POS_W-1:0]  META_UNITS = POS_W'(META_BYTES / ALIGN_BYTES);
  localparam logic [POS_W-1:0]  MIN_UNITS  = POS_W'(MIN_BLOCK_BYTES / ALIGN_BYTES);
  localparam logic [POS_W-1:0]  TAG_UNITS  = POS_W'(TAG_BYTES / ALIGN_BYTES);
  localparam logic [END_W-1:0]  MIN_HEAP_UNITS =
    END_W'((META_BYTES + MIN_BLOCK_BYTES) / ALIGN_BYTES);
  localparam logic [CFG_W-1:0]  HEAP_BYTES_MAX = CFG_W'(HEAP_UNITS * ALIGN_BYTES);
  localparam logic [CFG_W-1:0]  HEAP_BYTES_RST = 14'd8192;
  localparam logic [STEP_W-1:0] STEP_LIMIT = STEP_W'(HEAP_UNITS);

  typedef enum logic [1:0] {
    MODE_INIT    = 2'd0,
    MODE_ALLOC   = 2'd1,
    MODE_FREE    = 2'd2,
    MODE_REALLOC = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FAIL = 2'd1,
    ST_NONE = 2'd2
  } status_e;

  typedef struct packed {
    mode_e              mode;
    logic [FIELD_W-1:0] request_bytes;
    logic [FIELD_W-1:0] block_offset;
  } in_t;

  typedef struct packed {
    status_e            status;
    logic [FIELD_W-1:0] result_offset;
    logic               move_needed;
    logic [FIELD_W-1:0] copy_bytes;
  } out_t;

  typedef struct packed {
    logic              re;
    logic [SLOT_W-1:0] raddr;
    logic              we;
    logic [SLOT_W-1:0] waddr;
    logic [TAG_W-1:0]  wdata;
  } mem_req_t;

  typedef enum logic [4:0] {
    S_IDLE, S_START, S_AL_CHK, S_AL_USE, S_AL_DONE, S_CLAIM, S_CLAIM_REST,
    S_PT_HEAD, S_PT_FOOT, S_FR_RD, S_FR_SZ, S_FR_NX, S_FR_NXD, S_FR_PV,
    S_FR_PVD, S_FR_PPD, S_FR_MG, S_FR_MGD, S_RE_RD, S_RE_SZ, S_RE_NXD,
    S_RE_DEC, S_RE_PVD, S_RE_PPD, S_RE_FB, S_DONE
  } state_e;

  function automatic logic [POS_W-1:0] need_units(logic [FIELD_W-1:0] n);
    logic [FIELD_W:0] t;
    t = {1'b0, n} + (FIELD_W+1)'(2 * TAG_BYTES + ALIGN_BYTES - 1);
    return POS_W'(t >> UNIT_SHIFT);
  endfunction

  function automatic logic [FIELD_W-1:0] unit_to_byte(logic [POS_W-1:0] p);
    return {p[FIELD_W-UNIT_SHIFT-1:0], {UNIT_SHIFT{1'b0}}};
  endfunction

endpackage

[rtl/core/bta_ram.sv]
// ----------------------------------------------------------------------------
// bta_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module bta_ram #(
  parameter int unsigned WIDTH = 12,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

[rtl/core/bta_ctrl.sv]
// ----------------------------------------------------------------------------
// bta_ctrl
// Request sequencer: walks and rewrites boundary tags in the tag RAM.
// ----------------------------------------------------------------------------
module bta_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  bta_pkg::in_t                  in_data_i,
  output logic                          idle_o,
  input  logic [bta_pkg::CFG_W-1:0]     heap_bytes_i,
  output logic                          res_valid_o,
  input  logic                          res_take_i,
  output bta_pkg::out_t                 res_o,
  output bta_pkg::mem_req_t             mem_req_o,
  input  logic [bta_pkg::TAG_W-1:0]     mem_rdata_i
);
  import bta_pkg::*;

  state_e state_q, state_d, pt_ret_q, pt_ret_d, cl_ret_q, cl_ret_d;
  mode_e  mode_q, mode_d;
  status_e status_q, status_d;
  logic [FIELD_W-1:0] n_q, n_d, off_q, off_d, res_q, res_d, copy_q, copy_d;
  logic               ready_q, ready_d, move_q, move_d, nx_q, nx_d, fb_q, fb_d;
  logic               pt_used_q, pt_used_d;
  logic [END_W-1:0]   heap_end_q, heap_end_d;
  logic [STEP_W-1:0]  steps_q, steps_d;
  logic [OLD_W-1:0]   old_q, old_d;
  logic [POS_W-1:0]   hp_q, hp_d, cur_q, cur_d, pp_q, pp_d, b_q, b_d;
  logic [POS_W-1:0]   sz_q, sz_d, nsz_q, nsz_d, bs_q, bs_d, req_q, req_d;
  logic [POS_W-1:0]   pt_pos_q, pt_pos_d, pt_size_q, pt_size_d;
  logic [POS_W-1:0]   cl_pos_q, cl_pos_d, cl_avail_q, cl_avail_d, cl_req_q, cl_req_d;

  logic [POS_W-1:0]   rd_size, hdr_pos, heap_end_x, total, pt_foot;
  logic               rd_used, hdr_ok;
  logic [CFG_W-1:0]   hb_cap;
  logic [END_W-1:0]   init_units;
  logic [CFG_W-1:0]   old_bytes;

  assign rd_size    = POS_W'(mem_rdata_i[TAG_W-1:1]);
  assign rd_used    = mem_rdata_i[0];
  assign heap_end_x = POS_W'(heap_end_q);
  assign hdr_pos    = POS_W'(off_q[FIELD_W-1:UNIT_SHIFT]) - TAG_UNITS;
  assign hdr_ok     = (off_q[UNIT_SHIFT-1:0] == '0) &&
                      (POS_W'(off_q[FIELD_W-1:UNIT_SHIFT]) >= META_UNITS + TAG_UNITS) &&
                      (hdr_pos < heap_end_x);
  assign hb_cap     = (heap_bytes_i > HEAP_BYTES_MAX) ? HEAP_BYTES_MAX : heap_bytes_i;
  assign init_units = END_W'(hb_cap >> UNIT_SHIFT);
  assign total      = sz_q + rd_size + nsz_q;
  assign pt_foot    = pt_pos_q + pt_size_q - TAG_UNITS;
  assign old_bytes  = {old_q, {UNIT_SHIFT{1'b0}}};

  always_comb begin
    state_d    = state_q;
    pt_ret_d   = pt_ret_q;
    cl_ret_d   = cl_ret_q;
    mode_d     = mode_q;
    status_d   = status_q;
    n_d        = n_q;
    off_d      = off_q;
    res_d      = res_q;
    copy_d     = copy_q;
    ready_d    = ready_q;
    move_d     = move_q;
    nx_d       = nx_q;
    fb_d       = fb_q;
    pt_used_d  = pt_used_q;
    heap_end_d = heap_end_q;
    steps_d    = steps_q;
    old_d      = old_q;
    hp_d       = hp_q;
    cur_d      = cur_q;
    pp_d       = pp_q;
    b_d        = b_q;
    sz_d       = sz_q;
    nsz_d      = nsz_q;
    bs_d       = bs_q;
    req_d      = req_q;
    pt_pos_d   = pt_pos_q;
    pt_size_d  = pt_size_q;
    cl_pos_d   = cl_pos_q;
    cl_avail_d = cl_avail_q;
    cl_req_d   = cl_req_q;
    mem_req_o  = '0;
    idle_o     = 1'b0;
    res_valid_o = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        idle_o = 1'b1;
        if (in_valid_i) begin
          mode_d  = in_data_i.mode;
          n_d     = in_data_i.request_bytes;
          off_d   = in_data_i.block_offset;
          state_d = S_START;
        end
      end
      S_START: begin
        res_d    = '0;
        move_d   = 1'b0;
        copy_d   = '0;
        fb_d     = 1'b0;
        status_d = ST_FAIL;
        state_d  = S_DONE;
        if (mode_q == MODE_INIT) begin
          if (init_units < MIN_HEAP_UNITS) begin
            ready_d = 1'b0;
          end else begin
            heap_end_d = init_units;
            ready_d    = 1'b1;
            status_d   = ST_OK;
            pt_pos_d   = META_UNITS;
            pt_size_d  = POS_W'(init_units) - META_UNITS;
            pt_used_d  = 1'b0;
            pt_ret_d   = S_DONE;
            state_d    = S_PT_HEAD;
          end
        end else if (!ready_q) begin
          status_d = ST_FAIL;
        end else if (mode_q == MODE_ALLOC || (mode_q == MODE_REALLOC && off_q == '0)) begin
          if (n_q != '0) begin
            req_d   = need_units(n_q);
            cur_d   = META_UNITS;
            steps_d = '0;
            state_d = S_AL_CHK;
          end
        end else if (mode_q == MODE_FREE || n_q == '0) begin
          status_d = ST_NONE;
          if (off_q != '0 && hdr_ok) begin
            hp_d    = hdr_pos;
            state_d = S_FR_RD;
          end
        end else if (hdr_ok) begin
          hp_d    = hdr_pos;
          req_d   = need_units(n_q);
          state_d = S_RE_RD;
        end
      end
      S_AL_CHK: begin
        if (cur_q < heap_end_x && steps_q <= STEP_LIMIT) begin
          mem_req_o.re    = 1'b1;
          mem_req_o.raddr = cur_q[SLOT_W-1:0];
          state_d         = S_AL_USE;
        end else begin
          status_d = ST_FAIL;
          state_d  = S_DONE;
        end
      end
      S_AL_USE: begin
        if (rd_size == '0) begin
          status_d = ST_FAIL;
          state_d  = S_DONE;
        end else if (!rd_used && rd_size >= req_q) begin
          cl_pos_d   = cur_q;
          cl_avail_d = rd_size;
          cl_req_d   = req_q;
          cl_ret_d   = S_AL_DONE;
          state_d    = S_CLAIM;
        end else begin
          cur_d   = cur_q + rd_size;
          steps_d = steps_q + STEP_W'(1);
          state_d = S_AL_CHK;
        end
      end
      S_AL_DONE: begin
        status_d = ST_OK;
        res_d    = unit_to_byte(cur_q + TAG_UNITS);
        state_d  = S_DONE;
        if (fb_q) begin
          move_d  = 1'b1;
          copy_d  = (old_bytes < {1'b0, n_q}) ? old_bytes[FIELD_W-1:0] : n_q;
          state_d = S_FR_RD;
        end
      end
      S_CLAIM: begin
        pt_pos_d  = cl_pos_q;
        pt_used_d = 1'b1;
        state_d   = S_PT_HEAD;
        if (cl_avail_q - cl_req_q >= MIN_UNITS) begin
          pt_size_d = cl_req_q;
          pt_ret_d  = S_CLAIM_REST;
        end else begin
          pt_size_d = cl_avail_q;
          pt_ret_d  = cl_ret_q;
        end
      end
      S_CLAIM_REST: begin
        pt_pos_d  = cl_pos_q + cl_req_q;
        pt_size_d = cl_avail_q - cl_req_q;
        pt_used_d = 1'b0;
        pt_ret_d  = cl_ret_q;
        state_d   = S_PT_HEAD;
      end
      S_PT_HEAD: begin
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = pt_pos_q[SLOT_W-1:0];
        mem_req_o.wdata = {pt_size_q[TAG_W-2:0], pt_used_q};
        state_d         = S_PT_FOOT;
      end
      S_PT_FOOT: begin
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = pt_foot[SLOT_W-1:0];
        mem_req_o.wdata = {pt_size_q[TAG_W-2:0], pt_used_q};
        state_d         = pt_ret_q;
      end
      S_FR_RD: begin
        mem_req_o.re    = 1'b1;
        mem_req_o.raddr = hp_q[SLOT_W-1:0];
        state_d         = S_FR_SZ;
      end
      S_FR_SZ: begin
        sz_d      = rd_size;
        b_d       = hp_q;
        bs_d      = rd_size;
        pt_pos_d  = hp_q;
        pt_size_d = rd_size;
        pt_used_d = 1'b0;
        pt_ret_d  = S_FR_NX;
        state_d   = S_PT_HEAD;
      end
      S_FR_NX: begin
        nx_d    = 1'b0;
        state_d = S_FR_PV;
        if (sz_q != '0 && hp_q + sz_q < heap_end_x) begin
          mem_req_o.re    = 1'b1;
          mem_req_o.raddr = SLOT_W'(hp_q + sz_q);
          state_d         = S_FR_NXD;
        end
      end
      S_FR_NXD: begin
        nx_d    = !rd_used;
        state_d = S_FR_PV;
      end
      S_FR_PV: begin
        state_d = S_FR_MG;
        if (hp_q > META_UNITS) begin
          mem_req_o.re    = 1'b1;
          mem_req_o.raddr = SLOT_W'(hp_q - TAG_UNITS);
          state_d         = S_FR_PVD;
        end
      end
      S_FR_PVD: begin
        state_d = S_FR_MG;
        if (!(rd_size == '0 || rd_size > hp_q - META_UNITS)) begin
          pp_d            = hp_q - rd_size;
          mem_req_o.re    = 1'b1;
          mem_req_o.raddr = SLOT_W'(hp_q - rd_size);
          state_d         = S_FR_PPD;
        end
      end
      S_FR_PPD: begin
        state_d = S_FR_MG;
        if (!rd_used) begin
          b_d       = pp_q;
          bs_d      = rd_size + sz_q;
          pt_pos_d  = pp_q;
          pt_size_d = rd_size + sz_q;
          pt_used_d = 1'b0;
          pt_ret_d  = S_FR_MG;
          state_d   = S_PT_HEAD;
        end
      end
      S_FR_MG: begin
        state_d = S_DONE;
        if (nx_q) begin
          mem_req_o.re    = 1'b1;
          mem_req_o.raddr = SLOT_W'(hp_q + sz_q);
          state_d         = S_FR_MGD;
        end
      end
      S_FR_MGD: begin
        pt_pos_d  = b_q;
        pt_size_d = bs_q + rd_size;
        pt_used_d = 1'b0;
        pt_ret_d  = S_DONE;
        state_d   = S_PT_HEAD;
      end
      S_RE_RD: begin
        mem_req_o.re    = 1'b1;
        mem_req_o.raddr = hp_q[SLOT_W-1:0];
        state_d         = S_RE_SZ;
      end
      S_RE_SZ: begin
        sz_d    = rd_size;
        old_d   = (rd_size >= 2 * TAG_UNITS) ? OLD_W'(rd_size - 2 * TAG_UNITS) : '0;
        nx_d    = 1'b0;
        nsz_d   = '0;
        state_d = S_RE_DEC;
        if (rd_size != '0 && hp_q + rd_size < heap_end_x) begin
          mem_req_o.re    = 1'b1;
          mem_req_o.raddr = SLOT_W'(hp_q + rd_size);
          state_d         = S_RE_NXD;
        end
      end
      S_RE_NXD: begin
        nx_d    = !rd_used;
        nsz_d   = rd_used ? '0 : rd_size;
        state_d = S_RE_DEC;
      end
      S_RE_DEC: begin
        cl_pos_d = hp_q;
        cl_req_d = req_q;
        cl_ret_d = S_DONE;
        if (req_q <= sz_q) begin
          cl_avail_d = sz_q;
          status_d   = ST_OK;
          res_d      = off_q;
          state_d    = S_CLAIM;
        end else if (nx_q && sz_q + nsz_q >= req_q) begin
          cl_avail_d = sz_q + nsz_q;
          status_d   = ST_OK;
          res_d      = off_q;
          state_d    = S_CLAIM;
        end else if (hp_q > META_UNITS) begin
          mem_req_o.re    = 1'b1;
          mem_req_o.raddr = SLOT_W'(hp_q - TAG_UNITS);
          state_d         = S_RE_PVD;
        end else begin
          state_d = S_RE_FB;
        end
      end
      S_RE_PVD: begin
        state_d = S_RE_FB;
        if (!(rd_size == '0 || rd_size > hp_q - META_UNITS)) begin
          pp_d            = hp_q - rd_size;
          mem_req_o.re    = 1'b1;
          mem_req_o.raddr = SLOT_W'(hp_q - rd_size);
          state_d         = S_RE_PPD;
        end
      end
      S_RE_PPD: begin
        state_d = S_RE_FB;
        if (!rd_used && total >= req_q) begin
          cl_pos_d   = pp_q;
          cl_avail_d = total;
          cl_req_d   = req_q;
          cl_ret_d   = S_DONE;
          status_d   = ST_OK;
          res_d      = unit_to_byte(pp_q + TAG_UNITS);
          move_d     = 1'b1;
          copy_d     = old_bytes[FIELD_W-1:0];
          state_d    = S_CLAIM;
        end
      end
      S_RE_FB: begin
        fb_d    = 1'b1;
        cur_d   = META_UNITS;
        steps_d = '0;
        state_d = S_AL_CHK;
      end
      S_DONE: begin
        res_valid_o = 1'b1;
        if (res_take_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign res_o.status        = status_q;
  assign res_o.result_offset = res_q;
  assign res_o.move_needed   = move_q;
  assign res_o.copy_bytes    = copy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      ready_q    <= 1'b0;
      heap_end_q <= '0;
    end else begin
      state_q    <= state_d;
      ready_q    <= ready_d;
      heap_end_q <= heap_end_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pt_ret_q   <= pt_ret_d;
    cl_ret_q   <= cl_ret_d;
    mode_q     <= mode_d;
    status_q   <= status_d;
    n_q        <= n_d;
    off_q      <= off_d;
    res_q      <= res_d;
    copy_q     <= copy_d;
    move_q     <= move_d;
    nx_q       <= nx_d;
    fb_q       <= fb_d;
    pt_used_q  <= pt_used_d;
    steps_q    <= steps_d;
    old_q      <= old_d;
    hp_q       <= hp_d;
    cur_q      <= cur_d;
    pp_q       <= pp_d;
    b_q        <= b_d;
    sz_q       <= sz_d;
    nsz_q      <= nsz_d;
    bs_q       <= bs_d;
    req_q      <= req_d;
    pt_pos_q   <= pt_pos_d;
    pt_size_q  <= pt_size_d;
    cl_pos_q   <= cl_pos_d;
    cl_avail_q <= cl_avail_d;
    cl_req_q   <= cl_req_d;
  end

endmodule

[rtl/core/boundary_tag_first_fit_allocator.sv]
// ----------------------------------------------------------------------------
// boundary_tag_first_fit_allocator
// First-fit boundary-tag heap allocator that manages tag metadata only.
// ----------------------------------------------------------------------------
// One request is worked at a time; all heap tags live in a 1024 x 12 tag RAM
// with one write and one registered read port, and every tag read or write
// goes through that port. Allocate walks blocks first-fit from the heap start,
// then splits the chosen block and gives the result, so its time follows
// fragmentation. Realloc is worked in place, or as a full allocate plus a
// free when it falls back. A new request is taken while a result waits in
// the output register.
module boundary_tag_first_fit_allocator (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  bta_pkg::in_t              in_data_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output bta_pkg::out_t             out_data_o,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [bta_pkg::CFG_W-1:0] cfg_data_i
);
  import bta_pkg::*;

  logic [CFG_W-1:0] heap_bytes_q;
  logic             out_valid_q;
  out_t             out_data_q, res;
  logic             idle, res_valid, res_take;
  mem_req_t         mem_req;
  logic [TAG_W-1:0] mem_rdata;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = !idle;
  assign res_take    = res_valid && (!out_valid_q || !out_stall_i);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      heap_bytes_q <= HEAP_BYTES_RST;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        heap_bytes_q <= cfg_data_i;
      end
      if (res_take) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_take) begin
      out_data_q <= res;
    end
  end

  bta_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_data_i    (in_data_i),
    .idle_o       (idle),
    .heap_bytes_i (heap_bytes_q),
    .res_valid_o  (res_valid),
    .res_take_i   (res_take),
    .res_o        (res),
    .mem_req_o    (mem_req),
    .mem_rdata_i  (mem_rdata)
  );

  bta_ram #(
    .WIDTH (TAG_W),
    .DEPTH (HEAP_UNITS)
  ) u_tag_ram (
    .clk_i   (clk_i),
    .we_i    (mem_req.we),
    .waddr_i (mem_req.waddr),
    .wdata_i (mem_req.wdata),
    .re_i    (mem_req.re),
    .raddr_i (mem_req.raddr),
    .rdata_o (mem_rdata)
  );

endmodule

[rtl/core/bta_checker.sv]
// ----------------------------------------------------------------------------
// bta_checker
// Port-level checks on the allocator results.
// ----------------------------------------------------------------------------
module bta_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_stall_o,
  input bta_pkg::in_t              in_data_i,
  input logic                      out_valid_o,
  input logic                      out_stall_i,
  input bta_pkg::out_t             out_data_o,
  input logic                      cfg_valid_i,
  input logic                      cfg_ready_o,
  input logic [bta_pkg::CFG_W-1:0] cfg_data_i
);
  import bta_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("result dropped while stalled");

  a_fail_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status != ST_OK |->
      out_data_o.result_offset == '0 && !out_data_o.move_needed &&
      out_data_o.copy_bytes == '0)
    else $error("failed request carries payload");

  a_copy_move: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.move_needed |-> out_data_o.copy_bytes == '0)
    else $error("copy count without move");

  a_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.result_offset[UNIT_SHIFT-1:0] == '0 &&
      (out_data_o.status == ST_OK || out_data_o.status == ST_FAIL ||
       out_data_o.status == ST_NONE))
    else $error("bad result offset or status");

endmodule

bind boundary_tag_first_fit_allocator bta_checker u_bta_checker (.*);
